@@ hdl/pqa_pkg.sv @@
`default_nettype none

package pqa_pkg;

	localparam int NUM_Q  = 4;
	localparam int QIDX_W = 2;
	localparam int ACT_W  = 2;
	localparam int QN_W   = 3;
	localparam int TAG_W  = 16;
	localparam int TIME_W = 32;
	localparam int STOP_W = 4;
	localparam int STAT_W = 3;
	localparam int SLOT_W = 7;

	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_TAG_BITS    = 16;

	localparam logic [SLOT_W-1:0] SLOTS_RESET = 7'd2;
	localparam logic [QN_W-1:0]   Q_NONE      = 3'd4;

	typedef enum logic [ACT_W-1:0] {
		ACT_ENQ  = 2'd0,
		ACT_PULL = 2'd1,
		ACT_REL  = 2'd2
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_QUEUED   = 3'd0,
		ST_BAD_Q    = 3'd1,
		ST_NO_SLOT  = 3'd2,
		ST_PULLED   = 3'd3,
		ST_NONE     = 3'd4,
		ST_RELEASED = 3'd5,
		ST_REL_OVF  = 3'd6
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	// update request from the execute stage to the queue bookkeeping
	typedef struct packed {
		logic              enq;
		logic              rel;
		logic              pop;
		logic [QIDX_W-1:0] q;
	} qs_cmd_t;

	// per-queue status from the queue bookkeeping
	typedef struct packed {
		logic [NUM_Q-1:0] nonempty;
		logic [NUM_Q-1:0] has_free;
		logic [NUM_Q-1:0] not_full;
		logic [NUM_Q-1:0] below_limit;
	} qs_flags_t;

	typedef struct packed {
		logic            got;
		logic            sel_b;
		logic [QN_W-1:0] queue;
	} pick_t;

endpackage

`default_nettype wire

@@ hdl/pqa_if.sv @@
`default_nettype none

interface pqa_req_if;
	import pqa_pkg::*;
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [QN_W-1:0]   queue_number;
	logic [TAG_W-1:0]  job_tag;
	logic [TIME_W-1:0] arrival_time;
	logic [STOP_W-1:0] stop_mask;

	modport source (output valid, action, queue_number, job_tag, arrival_time, stop_mask,
		input ready);
	modport sink (input valid, action, queue_number, job_tag, arrival_time, stop_mask,
		output ready);
endinterface

interface pqa_rsp_if;
	import pqa_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [QN_W-1:0]   picked_queue;
	logic [TAG_W-1:0]  picked_tag;
	logic [TIME_W-1:0] picked_time;

	modport source (output valid, status, picked_queue, picked_tag, picked_time,
		input ready);
	modport sink (input valid, status, picked_queue, picked_tag, picked_time,
		output ready);
endinterface

interface pqa_cfg_if;
	import pqa_pkg::*;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hdl/pqa_ram.sv @@
`default_nettype none

module pqa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr0,
	input  logic [AW-1:0]    raddr1,
	output logic [WIDTH-1:0] rdata0,
	output logic [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

`default_nettype wire

@@ hdl/pqa_queue_state.sv @@
`default_nettype none

module pqa_queue_state #(
	parameter int QUEUE_DEPTH = pqa_pkg::DEF_QUEUE_DEPTH,
	localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pqa_pkg::qs_cmd_t                       cmd,
	input  logic                                   cfg_we,
	input  logic [pqa_pkg::SLOT_W-1:0]             cfg_slots,
	output pqa_pkg::qs_flags_t                     flags,
	output logic [pqa_pkg::NUM_Q-1:0][PTR_W-1:0]   head,
	output logic [pqa_pkg::NUM_Q-1:0][PTR_W-1:0]   tail
);

	import pqa_pkg::*;

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	logic [NUM_Q-1:0][PTR_W-1:0]  head_q;
	logic [NUM_Q-1:0][PTR_W-1:0]  tail_q;
	logic [NUM_Q-1:0][OCC_W-1:0]  occ_q;
	logic [NUM_Q-1:0][SLOT_W-1:0] free_q;
	logic [SLOT_W-1:0]            slots_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			free_q  <= {NUM_Q{SLOTS_RESET}};
			slots_q <= SLOTS_RESET;
		end else if (cfg_we) begin
			slots_q <= cfg_slots;
			free_q  <= {NUM_Q{cfg_slots}};
		end else begin
			if (cmd.enq) begin
				free_q[cmd.q] <= free_q[cmd.q] - 1'b1;
				tail_q[cmd.q] <= ptr_inc(tail_q[cmd.q]);
				occ_q[cmd.q]  <= occ_q[cmd.q] + 1'b1;
			end
			if (cmd.rel) begin
				free_q[cmd.q] <= free_q[cmd.q] + 1'b1;
			end
			if (cmd.pop) begin
				head_q[cmd.q] <= ptr_inc(head_q[cmd.q]);
				occ_q[cmd.q]  <= occ_q[cmd.q] - 1'b1;
			end
		end
	end

	always_comb begin
		for (int q = 0; q < NUM_Q; q++) begin
			flags.nonempty[q]    = (occ_q[q] != '0);
			flags.has_free[q]    = (free_q[q] != '0);
			flags.not_full[q]    = (occ_q[q] < OCC_W'(QUEUE_DEPTH));
			flags.below_limit[q] = (free_q[q] < slots_q);
		end
	end

	assign head = head_q;
	assign tail = tail_q;

endmodule

`default_nettype wire

@@ hdl/pqa_pick.sv @@
`default_nettype none

module pqa_pick (
	input  logic                        pair,
	input  logic                        ha,
	input  logic                        hb,
	input  logic                        stop_b,
	input  logic [pqa_pkg::QN_W-1:0]    prev,
	input  logic [pqa_pkg::TIME_W-1:0]  time_a,
	input  logic [pqa_pkg::TIME_W-1:0]  time_b,
	output pqa_pkg::pick_t              pick
);

	import pqa_pkg::*;

	logic [QN_W-1:0] qa;
	logic [QN_W-1:0] qb;

	assign qa = {2'b00, pair};
	assign qb = {2'b01, pair};

	always_comb begin
		pick.got   = ha | hb;
		pick.sel_b = 1'b0;
		pick.queue = qa;
		if (ha && hb) begin
			// older head wins; on a tie, avoid the pair's previous pick
			if (time_a < time_b) begin
				pick.sel_b = 1'b0;
			end else if (time_a > time_b) begin
				pick.sel_b = 1'b1;
			end else begin
				pick.sel_b = (prev == qa);
			end
			pick.queue = pick.sel_b ? qb : qa;
		end else if (ha) begin
			pick.sel_b = 1'b0;
			pick.queue = qa;
		end else begin
			// second queue ready, or nothing ready: record the second queue, or none if stopped
			pick.sel_b = 1'b1;
			pick.queue = (!hb && stop_b) ? Q_NONE : qb;
		end
	end

endmodule

`default_nettype wire

@@ hdl/paired_queue_oldest_first_arbiter_core.sv @@
// Paired-queue oldest-first job arbiter.
//
// Channels: req carries one command beat (enqueue, pull or release) with its
// queue number, job tag, arrival time and stop mask; rsp returns exactly one
// result beat per command; cfg writes the per-queue slot count and resets the
// free-slot pools of all four queues. cfg is always ready and is meant to be
// written only while no command is in flight.
// Sequence: the command beat is taken in the idle state while both pair
// heads are read from the entry RAM; the execute state then compares the
// heads, updates pointers and counters and loads the result register.
// req.ready stays low during execute, so the next command is not taken
// until the last one has committed.
// Stall: a result waiting in the output register does not block the next
// command beat; that command is taken and then holds in execute, with
// req.ready low, until rsp drains.
// Reset: all queues empty, free slots 2 per queue, turn bit and previous picks
// cleared. The entry RAM is not cleared; only written entries are ever used.

`default_nettype none

module paired_queue_oldest_first_arbiter_core #(
	parameter int QUEUE_DEPTH = pqa_pkg::DEF_QUEUE_DEPTH,
	parameter int TAG_BITS    = pqa_pkg::DEF_TAG_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	pqa_req_if.sink    req,
	pqa_rsp_if.source  rsp,
	pqa_cfg_if.sink    cfg
);

	import pqa_pkg::*;

	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int ETAG_W    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int ENT_W     = ETAG_W + TIME_W;
	localparam int ADDR_W    = QIDX_W + PTR_W;
	localparam int RAM_DEPTH = NUM_Q << PTR_W;

	fsm_t fsm_q;
	fsm_t fsm_d;
	logic req_ready;
	logic exec;
	logic accept;
	logic commit;

	qs_cmd_t                     cmd;
	qs_flags_t                   flags;
	logic [NUM_Q-1:0][PTR_W-1:0] head;
	logic [NUM_Q-1:0][PTR_W-1:0] tail;

	logic                  turn_q;
	logic [1:0][QN_W-1:0]  prev_pick_q;

	// accept-cycle pair selection
	logic [NUM_Q-1:0] avail;
	logic             p_first;
	logic             first_has;
	logic             pair_s0;

	logic [ACT_W-1:0]  act_s1;
	logic [QN_W-1:0]   qn_s1;
	logic [ETAG_W-1:0] tag_s1;
	logic [TIME_W-1:0] time_s1;
	logic              pair_s1;
	logic              first_s1;
	logic              ha_s1;
	logic              hb_s1;
	logic              stop_b_s1;

	logic              ram_we;
	logic [ADDR_W-1:0] waddr;
	logic [ENT_W-1:0]  wdata;
	logic [ADDR_W-1:0] raddr0;
	logic [ADDR_W-1:0] raddr1;
	logic [ENT_W-1:0]  rdata0;
	logic [ENT_W-1:0]  rdata1;
	logic [ENT_W-1:0]  ent;

	pick_t pick;

	logic [STAT_W-1:0] res_status;
	logic [QN_W-1:0]   res_q;
	logic [TAG_W-1:0]  res_tag;
	logic [TIME_W-1:0] res_time;
	logic              q_ok;
	logic [QIDX_W-1:0] qi_s1;

	logic              rsp_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [QN_W-1:0]   picked_queue_q;
	logic [TAG_W-1:0]  picked_tag_q;
	logic [TIME_W-1:0] picked_time_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			FSM_IDLE: begin
				if (req.valid) fsm_d = FSM_EXEC;
			end
			FSM_EXEC: begin
				if (commit) fsm_d = FSM_IDLE;
			end
			default: fsm_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		exec      = 1'b0;
		case (fsm_q)
			FSM_IDLE: req_ready = 1'b1;
			FSM_EXEC: exec      = 1'b1;
			default: begin
				req_ready = 1'b0;
				exec      = 1'b0;
			end
		endcase
	end

	assign req.ready = req_ready;
	assign accept    = req.valid & req_ready;
	assign commit    = exec & (~rsp_valid_q | rsp.ready);

	assign cfg.ready = 1'b1;

	pqa_queue_state #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg.valid),
		.cfg_slots (cfg.data),
		.flags     (flags),
		.head      (head),
		.tail      (tail)
	);

	// pick the pair that the pull will end up serving and read both heads
	assign avail     = flags.nonempty & ~req.stop_mask;
	assign p_first   = ~turn_q;
	assign first_has = avail[{1'b0, p_first}] | avail[{1'b1, p_first}];
	assign pair_s0   = first_has ? p_first : turn_q;
	assign raddr0    = {1'b0, pair_s0, head[{1'b0, pair_s0}]};
	assign raddr1    = {1'b1, pair_s0, head[{1'b1, pair_s0}]};

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1    <= req.action;
			qn_s1     <= req.queue_number;
			tag_s1    <= req.job_tag[ETAG_W-1:0];
			time_s1   <= req.arrival_time;
			pair_s1   <= pair_s0;
			first_s1  <= first_has;
			ha_s1     <= avail[{1'b0, pair_s0}];
			hb_s1     <= avail[{1'b1, pair_s0}];
			stop_b_s1 <= req.stop_mask[{1'b1, pair_s0}];
		end
	end

	pqa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (RAM_DEPTH)
	) u_entry_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (accept),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	pqa_pick u_pick (
		.pair   (pair_s1),
		.ha     (ha_s1),
		.hb     (hb_s1),
		.stop_b (stop_b_s1),
		.prev   (prev_pick_q[pair_s1]),
		.time_a (rdata0[TIME_W-1:0]),
		.time_b (rdata1[TIME_W-1:0]),
		.pick   (pick)
	);

	// execute
	assign qi_s1 = qn_s1[QIDX_W-1:0];
	assign q_ok  = (qn_s1 < QN_W'(NUM_Q));
	assign ent   = pick.sel_b ? rdata1 : rdata0;
	assign waddr = {qi_s1, tail[qi_s1]};
	assign wdata = {tag_s1, time_s1};

	always_comb begin
		res_status = ST_NONE;
		res_q      = Q_NONE;
		res_tag    = '0;
		res_time   = '0;
		cmd        = '0;
		cmd.q      = qi_s1;
		ram_we     = 1'b0;
		case (act_s1)
			ACT_ENQ: begin
				if (!q_ok) begin
					res_status = ST_BAD_Q;
				end else if (!(flags.has_free[qi_s1] && flags.not_full[qi_s1])) begin
					res_status = ST_NO_SLOT;
				end else begin
					res_status = ST_QUEUED;
					cmd.enq    = commit;
					ram_we     = commit;
				end
			end
			ACT_REL: begin
				if (!q_ok) begin
					res_status = ST_BAD_Q;
				end else if (!flags.below_limit[qi_s1]) begin
					res_status = ST_REL_OVF;
				end else begin
					res_status = ST_RELEASED;
					cmd.rel    = commit;
				end
			end
			ACT_PULL: begin
				if (pick.got) begin
					res_status = ST_PULLED;
					res_q      = pick.queue;
					res_tag    = TAG_W'(ent[ENT_W-1:TIME_W]);
					res_time   = ent[TIME_W-1:0];
					cmd.pop    = commit;
					cmd.q      = pick.queue[QIDX_W-1:0];
				end
			end
			default: res_status = ST_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_q      <= 1'b0;
			prev_pick_q <= '0;
		end else if (commit && act_s1 == ACT_PULL) begin
			// a hit on the first pair leaves the turn toggled once, else twice
			turn_q               <= turn_q ^ first_s1;
			prev_pick_q[pair_s1] <= pick.queue;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q       <= res_status;
			picked_queue_q <= res_q;
			picked_tag_q   <= res_tag;
			picked_time_q  <= res_time;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.picked_queue = picked_queue_q;
	assign rsp.picked_tag   = picked_tag_q;
	assign rsp.picked_time  = picked_time_q;

endmodule

`default_nettype wire

@@ hdl/pqa_checker.sv @@
`default_nettype none

module pqa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [pqa_pkg::STAT_W-1:0]   status,
	input logic [pqa_pkg::QN_W-1:0]     picked_queue,
	input logic [pqa_pkg::TAG_W-1:0]    picked_tag,
	input logic [pqa_pkg::TIME_W-1:0]   picked_time
);

	import pqa_pkg::*;

	// hold a stalled result beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({status, picked_queue, picked_tag, picked_time}))
		else $error("stalled result beat changed");

	// one command in flight: input closes right after a beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken during execute");

	a_pull_queue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_PULLED |-> picked_queue != Q_NONE
			&& picked_queue[QN_W-1] == 1'b0)
		else $error("pulled result without a queue");

	a_other_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_PULLED |-> picked_queue == Q_NONE
			&& picked_tag == '0 && picked_time == '0)
		else $error("non-pull result carries job fields");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_REL_OVF)
		else $error("undefined status code");

endmodule

bind paired_queue_oldest_first_arbiter_core pqa_checker u_pqa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (req.valid),
	.in_ready     (req.ready),
	.out_valid    (rsp.valid),
	.out_ready    (rsp.ready),
	.status       (rsp.status),
	.picked_queue (rsp.picked_queue),
	.picked_tag   (rsp.picked_tag),
	.picked_time  (rsp.picked_time)
);

`default_nettype wire

@@ bench/paired_queue_oldest_first_arbiter_checker.sv @@
`default_nettype none

module paired_queue_oldest_first_arbiter_checker (
	input  logic clk,
	input  logic arst_n,
	pqa_req_if   req,
	pqa_rsp_if   rsp,
	pqa_cfg_if   cfg,
	output int   mismatches,
	output int   checked,
	output int   pending
);
	import pqa_pkg::*;

	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	typedef struct {
		status_t           status;
		logic [QN_W-1:0]   queue;
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] stamp;
	} job_result_t;

	logic [TAG_W-1:0]  job_tag_mem  [NUM_Q][DEPTH];
	logic [TIME_W-1:0] job_time_mem [NUM_Q][DEPTH];
	logic [PTR_W-1:0]  rd_ptr       [NUM_Q];
	logic [PTR_W-1:0]  wr_ptr       [NUM_Q];
	logic [SLOT_W-1:0] depth_cnt    [NUM_Q];
	logic [SLOT_W-1:0] free_cnt     [NUM_Q];
	logic [SLOT_W-1:0] slot_limit;
	logic              turn;
	logic [QN_W-1:0]   last_pick    [2];

	job_result_t due_results[$];
	int          err_cnt;
	int          beat_cnt;

	function automatic void clear_queues();
		for (int q = 0; q < NUM_Q; q++) begin
			rd_ptr[q]    = '0;
			wr_ptr[q]    = '0;
			depth_cnt[q] = '0;
			free_cnt[q]  = SLOTS_RESET;
		end
		slot_limit   = SLOTS_RESET;
		turn         = 1'b0;
		last_pick[0] = '0;
		last_pick[1] = '0;
	endfunction

	function automatic job_result_t dispatch_command(
		input logic [ACT_W-1:0]  act,
		input logic [QN_W-1:0]   qn,
		input logic [TAG_W-1:0]  tag,
		input logic [TIME_W-1:0] stamp,
		input logic [STOP_W-1:0] stop
	);
		job_result_t       r;
		logic [QIDX_W-1:0] q;
		logic [QN_W-1:0]   a;
		logic [QN_W-1:0]   b;
		logic [QN_W-1:0]   chosen;
		logic              pair;
		logic              ha;
		logic              hb;
		logic              got;

		r = '{ST_NONE, Q_NONE, '0, '0};
		q = qn[QIDX_W-1:0];
		case (act)
			ACT_ENQ: begin
				if (qn >= NUM_Q) begin
					r.status = ST_BAD_Q;
				end else if (free_cnt[q] == 0 || depth_cnt[q] >= DEPTH) begin
					r.status = ST_NO_SLOT;
				end else begin
					free_cnt[q]--;
					job_tag_mem[q][wr_ptr[q]]  = tag;
					job_time_mem[q][wr_ptr[q]] = stamp;
					wr_ptr[q]++;
					depth_cnt[q]++;
					r.status = ST_QUEUED;
				end
			end
			ACT_REL: begin
				if (qn >= NUM_Q) begin
					r.status = ST_BAD_Q;
				end else if (free_cnt[q] >= slot_limit) begin
					r.status = ST_REL_OVF;
				end else begin
					free_cnt[q]++;
					r.status = ST_RELEASED;
				end
			end
			ACT_PULL: begin
				got    = 1'b0;
				chosen = Q_NONE;
				pair   = 1'b0;
				// pair 0 is stage/get, pair 1 is migrate/put; try the other pair once
				for (int tries = 0; tries < 2 && !got; tries++) begin
					turn = ~turn;
					pair = turn;
					a    = {2'b00, turn};
					b    = a + 3'd2;
					if (stop[a[QIDX_W-1:0]])
						a = Q_NONE;
					if (stop[b[QIDX_W-1:0]])
						b = Q_NONE;
					ha = (a != Q_NONE) && (depth_cnt[a[QIDX_W-1:0]] != 0);
					hb = (b != Q_NONE) && (depth_cnt[b[QIDX_W-1:0]] != 0);
					if (ha && hb) begin
						if (job_time_mem[a[QIDX_W-1:0]][rd_ptr[a[QIDX_W-1:0]]] <
								job_time_mem[b[QIDX_W-1:0]][rd_ptr[b[QIDX_W-1:0]]])
							chosen = a;
						else if (job_time_mem[a[QIDX_W-1:0]][rd_ptr[a[QIDX_W-1:0]]] >
								job_time_mem[b[QIDX_W-1:0]][rd_ptr[b[QIDX_W-1:0]]])
							chosen = b;
						else
							chosen = (last_pick[pair] == a) ? b : a;
					end else begin
						chosen = ha ? a : b;
					end
					if (chosen != Q_NONE && depth_cnt[chosen[QIDX_W-1:0]] != 0) begin
						q       = chosen[QIDX_W-1:0];
						r.queue = chosen;
						r.tag   = job_tag_mem[q][rd_ptr[q]];
						r.stamp = job_time_mem[q][rd_ptr[q]];
						rd_ptr[q]++;
						depth_cnt[q]--;
						got = 1'b1;
					end
				end
				last_pick[pair] = chosen;
				r.status = got ? ST_PULLED : ST_NONE;
			end
			default: begin
				r.status = ST_NONE;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_queues();
			due_results.delete();
			err_cnt  = 0;
			beat_cnt = 0;
			mismatches <= 0;
			checked    <= 0;
			pending    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				slot_limit = cfg.data;
				for (int q = 0; q < NUM_Q; q++)
					free_cnt[q] = cfg.data;
			end
			if (req.valid && req.ready)
				due_results.push_back(dispatch_command(req.action, req.queue_number,
					req.job_tag, req.arrival_time, req.stop_mask));
			if (rsp.valid && rsp.ready) begin
				beat_cnt++;
				if (due_results.size() == 0) begin
					$error("result beat with nothing outstanding: status %0d", rsp.status);
					err_cnt++;
				end else begin
					job_result_t want;
					want = due_results.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("picked_queue", 32'(want.queue), 32'(rsp.picked_queue));
					check_field("picked_tag", 32'(want.tag), 32'(rsp.picked_tag));
					check_field("picked_time", want.stamp, rsp.picked_time);
				end
			end
			mismatches <= err_cnt;
			checked    <= beat_cnt;
			pending    <= due_results.size();
		end
	end

endmodule

`default_nettype wire

@@ bench/paired_queue_oldest_first_arbiter_core_test.sv @@
`default_nettype none

module paired_queue_oldest_first_arbiter_core_test;
	import pqa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	localparam logic [ACT_W-1:0]  ACT_SPARE = 2'd3;
	localparam logic [QN_W-1:0]   Q_STAGE   = 3'd0;
	localparam logic [QN_W-1:0]   Q_MIGRATE = 3'd1;
	localparam logic [QN_W-1:0]   Q_GET     = 3'd2;
	localparam logic [QN_W-1:0]   Q_PUT     = 3'd3;
	localparam logic [QN_W-1:0]   Q_TOP_BAD = 3'd7;
	localparam logic [STOP_W-1:0] STOP_NONE = 4'h0;
	localparam logic [STOP_W-1:0] STOP_ALL  = 4'hF;
	localparam logic [STOP_W-1:0] STOP_PAIR0 = 4'b0101;

	logic clk      = 1'b0;
	logic arst_n   = 1'b0;
	logic rsp_hold = 1'b0;
	logic calm     = 1'b0;
	int   rsp_gap;
	int   rsp_draw;
	int   cycle_count = 0;
	int   commands_sent = 0;
	int   mismatches;
	int   checked;
	int   pending;

	pqa_req_if req_ch ();
	pqa_rsp_if rsp_ch ();
	pqa_cfg_if cfg_ch ();

	paired_queue_oldest_first_arbiter_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	paired_queue_oldest_first_arbiter_checker scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg       (cfg_ch),
		.mismatches(mismatches),
		.checked   (checked),
		.pending   (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("paired_queue_oldest_first_arbiter_core: mismatch");
			$finish;
		end
	end

	// result side: random stall after each beat, plus the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_gap <= 0;
		end else if (rsp_hold) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_gap != 0) begin
			rsp_gap <= rsp_gap - 1;
			rsp_ch.ready <= 1'b0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			rsp_draw = calm ? 0 : $urandom_range(0, 17);
			rsp_gap <= rsp_draw;
			rsp_ch.ready <= (rsp_draw == 0);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// hold results back long enough for the block to stall its input
	initial begin
		wait (commands_sent >= 300);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [QN_W-1:0] qn,
		input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] stamp,
		input logic [STOP_W-1:0] stop);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.action       <= act;
		req_ch.queue_number <= qn;
		req_ch.job_tag      <= tag;
		req_ch.arrival_time <= stamp;
		req_ch.stop_mask    <= stop;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		commands_sent++;
	endtask

	task automatic random_command(input int enq_pct, input int pull_pct,
		input logic [QN_W-1:0] only_q);
		logic [ACT_W-1:0]  act;
		logic [QN_W-1:0]   qn;
		logic [TIME_W-1:0] stamp;
		logic [STOP_W-1:0] stop;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < enq_pct)
			act = ACT_ENQ;
		else if (roll < enq_pct + pull_pct)
			act = ACT_PULL;
		else if (roll < 97)
			act = ACT_REL;
		else
			act = ACT_SPARE;
		if (only_q != Q_NONE)
			qn = only_q;
		else if ($urandom_range(0, 15) < 14)
			qn = QN_W'($urandom_range(0, NUM_Q - 1));
		else
			qn = QN_W'($urandom_range(NUM_Q, 7));
		// small times make ties between pair heads common
		case ($urandom_range(0, 3))
			0: stamp = $urandom;
			1: stamp = 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: stamp = $urandom_range(0, 5);
		endcase
		stop = ($urandom_range(0, 3) == 0) ? STOP_W'($urandom_range(0, 15)) : STOP_NONE;
		send_cmd(act, qn, TAG_W'($urandom), stamp, stop);
	endtask

	task automatic write_slots(input logic [SLOT_W-1:0] value);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		req_ch.valid        = 1'b0;
		req_ch.action       = ACT_ENQ;
		req_ch.queue_number = Q_STAGE;
		req_ch.job_tag      = '0;
		req_ch.arrival_time = '0;
		req_ch.stop_mask    = STOP_NONE;
		cfg_ch.valid        = 1'b0;
		cfg_ch.data         = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad queues, overflowing release, unused action, empty pull
		send_cmd(ACT_ENQ, Q_TOP_BAD, 16'hFFFF, 32'hFFFF_FFFF, STOP_ALL);
		send_cmd(ACT_REL, Q_NONE, 16'h0000, 32'h0, STOP_NONE);
		send_cmd(ACT_REL, Q_STAGE, 16'h0000, 32'h0, STOP_NONE);
		send_cmd(ACT_SPARE, Q_GET, 16'hA5A5, 32'h5A5A_5A5A, STOP_NONE);
		send_cmd(ACT_PULL, Q_TOP_BAD, 16'h0, 32'h0, STOP_NONE);
		// fill until no slot, with equal times across each pair
		send_cmd(ACT_ENQ, Q_STAGE, 16'hFFFF, 32'hFFFF_FFFF, STOP_NONE);
		send_cmd(ACT_ENQ, Q_GET, 16'h0000, 32'hFFFF_FFFF, STOP_NONE);
		send_cmd(ACT_ENQ, Q_STAGE, 16'h1234, 32'h0, STOP_NONE);
		send_cmd(ACT_ENQ, Q_STAGE, 16'h4321, 32'h1, STOP_NONE);
		send_cmd(ACT_ENQ, Q_MIGRATE, 16'h0005, 32'h0, STOP_NONE);
		send_cmd(ACT_ENQ, Q_PUT, 16'h0006, 32'h0, STOP_NONE);
		send_cmd(ACT_ENQ, Q_PUT, 16'h0007, 32'h8000_0000, STOP_NONE);
		// pulls with every queue stopped, one pair stopped, then drain
		send_cmd(ACT_PULL, Q_TOP_BAD, 16'h0, 32'h0, STOP_NONE);
		send_cmd(ACT_PULL, Q_STAGE, 16'h0, 32'h0, STOP_ALL);
		send_cmd(ACT_PULL, Q_STAGE, 16'h0, 32'h0, STOP_PAIR0);
		repeat (5)
			send_cmd(ACT_PULL, Q_MIGRATE, 16'h0, 32'h0, STOP_NONE);
		send_cmd(ACT_REL, Q_STAGE, 16'h0, 32'h0, STOP_NONE);
		send_cmd(ACT_REL, Q_STAGE, 16'h0, 32'h0, STOP_NONE);
		send_cmd(ACT_REL, Q_STAGE, 16'h0, 32'h0, STOP_NONE);
		send_cmd(ACT_REL, Q_MIGRATE, 16'h0, 32'h0, STOP_NONE);
		send_cmd(ACT_REL, Q_GET, 16'h0, 32'h0, STOP_NONE);
		send_cmd(ACT_REL, Q_PUT, 16'h0, 32'h0, STOP_NONE);

		repeat (120) random_command(40, 30, Q_NONE);

		// fill one queue past its depth, then refresh the pool and push again
		write_slots(7'd64);
		repeat (66) random_command(100, 0, Q_PUT);
		write_slots(7'd64);
		repeat (3) random_command(100, 0, Q_PUT);
		repeat (100) random_command(55, 30, Q_NONE);

		write_slots(7'd1);
		calm <= 1'b1;
		repeat (150) random_command(35, 35, Q_NONE);
		calm <= 1'b0;

		write_slots(7'd63);
		repeat (120) random_command(40, 30, Q_NONE);

		write_slots(SLOT_W'($urandom_range(3, 62)));
		repeat (100) random_command(40, 30, Q_NONE);

		write_slots(SLOT_W'(2));
		repeat (60) random_command(15, 60, Q_NONE);

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d commands over slot counts 1, 2, 63, 64 and one random, %0d results checked",
			commands_sent, checked);
		$display("covered bad queues, full queues, release overflow, stopped pairs, long stall");
		if (mismatches == 0 && pending == 0)
			$display("paired_queue_oldest_first_arbiter_core: match");
		else
			$display("paired_queue_oldest_first_arbiter_core: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hdl/pqa_pkg.sv
hdl/pqa_if.sv
hdl/pqa_ram.sv
hdl/pqa_queue_state.sv
hdl/pqa_pick.sv
hdl/paired_queue_oldest_first_arbiter_core.sv
hdl/pqa_checker.sv
bench/paired_queue_oldest_first_arbiter_checker.sv
bench/paired_queue_oldest_first_arbiter_core_test.sv
